### design/stmp_pkg.sv
`timescale 1ns / 1ps
package stmp_pkg;

  // Input actions
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // Matrix selectors for a load
  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Steps of the shared shift-add multiplier
  localparam logic [3:0] MS_HAB   = 4'd0;   // maxA * maxB
  localparam logic [3:0] MS_HABC  = 4'd1;   // * maxC
  localparam logic [3:0] MS_LAB   = 4'd2;   // minA * minB
  localparam logic [3:0] MS_LABC  = 4'd3;   // * minC, form numerator difference
  localparam logic [3:0] MS_N2    = 4'd4;   // n * n
  localparam logic [3:0] MS_N3    = 4'd5;   // n^2 * n
  localparam logic [3:0] MS_N6    = 4'd6;   // n^3 * n^3
  localparam logic [3:0] MS_NUM   = 4'd7;   // difference * n^6
  localparam logic [3:0] MS_SAB   = 4'd8;   // sumA * sumB
  localparam logic [3:0] MS_DEN   = 4'd9;   // * sumC
  localparam logic [3:0] MS_SCALE = 4'd10;  // scale * D accumulator

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_we;
    logic       rd_capture;
    logic       out_report;
    logic       out_read;
    logic       clr_we;
    logic       st_upd;
    logic       st_first;
    logic       sel_j;
    logic       mac_clr;
    logic       mac_mul;
    logic       mac_acc;
    logic       mac_d;
    logic       p_we;
    logic       d_we;
    logic       mul_start;
    logic [3:0] mul_step;
    logic       div_start;
    logic       scale_load;
  } stmp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic den_zero;
  } stmp_sts_t;

endpackage

### design/scaled_triple_matrix_product.sv
`timescale 1ns / 1ps
// Channel   Ports                                          Direction
// input     in_valid/in_ready, in_action .. in_value       into the block
// result    out_valid/out_ready, out_result_kind .. flag   out of the block
// config    cfg_valid/cfg_ready, cfg_data (matrix_size)    into the block
//
// A read's result comes from a registered memory read.
// A compute's length is set by the shared shift-add multiplier and the
// single-port reads of the element memories; a zero divisor skips the divider.
// After reset a clearing pass zeroes the product memory; in_ready stays low
// until it ends. cfg_ready is always high.
// One item is in work at a time; a waiting result holds off the input channel.
module scaled_triple_matrix_product #(
  parameter int MAX_DIM = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [1:0]         in_matrix_select,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic [7:0]         in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic signed [63:0] out_element,
  output logic signed [63:0] out_scale,
  output logic               out_divide_by_zero,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);
  import stmp_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);

  stmp_cmd_t     cmd;
  stmp_sts_t     sts;
  logic [IW-1:0] idx_i, idx_j, idx_k;
  logic [CW-1:0] n_use;

  stmp_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .out_valid(out_valid), .out_ready(out_ready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts),
    .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k), .n_use(n_use)
  );

  stmp_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k), .n_use(n_use),
    .in_matrix_select(in_matrix_select), .in_row(in_row), .in_col(in_col),
    .in_value(in_value),
    .out_result_kind(out_result_kind), .out_element(out_element),
    .out_scale(out_scale), .out_divide_by_zero(out_divide_by_zero)
  );

endmodule

### design/stmp_ram.sv
`timescale 1ns / 1ps
module stmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/stmp_ctrl.sv
`timescale 1ns / 1ps
module stmp_ctrl #(
  parameter int MAX_DIM = 16,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int CW = $clog2(MAX_DIM + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data,
  output stmp_pkg::stmp_cmd_t cmd,
  input  stmp_pkg::stmp_sts_t sts,
  output logic [IW-1:0]       idx_i,
  output logic [IW-1:0]       idx_j,
  output logic [IW-1:0]       idx_k,
  output logic [CW-1:0]       n_use
);
  import stmp_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_RD_OUT = 5'd2;
  localparam logic [4:0] S_ST_RD  = 5'd3;
  localparam logic [4:0] S_ST_UPD = 5'd4;
  localparam logic [4:0] S_MUL    = 5'd5;
  localparam logic [4:0] S_MULW   = 5'd6;
  localparam logic [4:0] S_DIV    = 5'd7;
  localparam logic [4:0] S_DIVW   = 5'd8;
  localparam logic [4:0] S_SCL    = 5'd9;
  localparam logic [4:0] S_P_RD   = 5'd10;
  localparam logic [4:0] S_P_MUL  = 5'd11;
  localparam logic [4:0] S_P_ACC  = 5'd12;
  localparam logic [4:0] S_D_RD   = 5'd13;
  localparam logic [4:0] S_D_MUL  = 5'd14;
  localparam logic [4:0] S_D_ACC  = 5'd15;
  localparam logic [4:0] S_D_MS   = 5'd16;
  localparam logic [4:0] S_D_MW   = 5'd17;
  localparam logic [4:0] S_D_WR   = 5'd18;
  localparam logic [4:0] S_REPORT = 5'd19;

  localparam logic [IW-1:0] IDX_TOP = IW'(MAX_DIM - 1);

  logic [4:0]    state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [3:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [4:0]    size_r, size_nxt;
  logic [IW-1:0] nm1;
  logic          in_fire;
  logic          i_last, j_last, k_last;

  // Clamp the size register to the range in use
  always_comb begin
    if (size_r == 5'd0) begin
      n_use = CW'(1);
    end else if (32'(size_r) > MAX_DIM) begin
      n_use = CW'(MAX_DIM);
    end else begin
      n_use = CW'(size_r);
    end
  end

  assign nm1    = IW'(n_use - CW'(1));
  assign i_last = (i_r == nm1);
  assign j_last = (j_r == nm1);
  assign k_last = (k_r == nm1);

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;
  assign idx_i     = i_r;
  assign idx_j     = j_r;
  assign idx_k     = k_r;

  // Sequence loads, reads and the compute phases
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    size_nxt      = cfg_valid ? cfg_data : size_r;
    cmd           = '0;
    cmd.mul_step  = step_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLR: begin
        cmd.clr_we = 1'b1;
        if (j_r == IDX_TOP) begin
          j_nxt = '0;
          if (i_r == IDX_TOP) begin
            i_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_LOAD: cmd.load_we = 1'b1;
            ACT_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = S_ST_RD;
            end
            ACT_READ: begin
              cmd.rd_capture = 1'b1;
              state_nxt      = S_RD_OUT;
            end
            default: ;
          endcase
        end
      end
      S_RD_OUT: begin
        cmd.out_read  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_ST_RD: state_nxt = S_ST_UPD;
      S_ST_UPD: begin
        cmd.st_upd   = 1'b1;
        cmd.st_first = (i_r == '0) && (k_r == '0);
        state_nxt    = S_ST_RD;
        if (k_last) begin
          k_nxt = '0;
          if (i_last) begin
            i_nxt     = '0;
            step_nxt  = MS_HAB;
            state_nxt = S_MUL;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MULW;
      end
      S_MULW: begin
        if (sts.mul_done) begin
          if (step_r == MS_DEN) begin
            state_nxt = S_DIV;
          end else begin
            step_nxt  = step_r + 4'd1;
            state_nxt = S_MUL;
          end
        end
      end
      S_DIV: begin
        if (sts.den_zero) begin
          state_nxt = S_SCL;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_nxt = S_SCL;
        end
      end
      S_SCL: begin
        cmd.scale_load = 1'b1;
        cmd.mac_clr    = 1'b1;
        step_nxt       = MS_SCALE;
        state_nxt      = S_P_RD;
      end
      S_P_RD: begin
        cmd.sel_j = 1'b1;
        state_nxt = S_P_MUL;
      end
      S_P_MUL: begin
        cmd.sel_j   = 1'b1;
        cmd.mac_mul = 1'b1;
        state_nxt   = S_P_ACC;
      end
      S_P_ACC: begin
        cmd.sel_j   = 1'b1;
        cmd.mac_acc = 1'b1;
        state_nxt   = S_P_RD;
        if (k_last) begin
          cmd.p_we    = 1'b1;
          cmd.mac_clr = 1'b1;
          k_nxt       = '0;
          if (j_last) begin
            j_nxt = '0;
            if (i_last) begin
              i_nxt     = '0;
              state_nxt = S_D_RD;
            end else begin
              i_nxt = i_r + IW'(1);
            end
          end else begin
            j_nxt = j_r + IW'(1);
          end
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      S_D_RD: begin
        cmd.sel_j = 1'b1;
        state_nxt = S_D_MUL;
      end
      S_D_MUL: begin
        cmd.sel_j   = 1'b1;
        cmd.mac_d   = 1'b1;
        cmd.mac_mul = 1'b1;
        state_nxt   = S_D_ACC;
      end
      S_D_ACC: begin
        cmd.sel_j   = 1'b1;
        cmd.mac_acc = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_D_MS;
        end else begin
          k_nxt     = k_r + IW'(1);
          state_nxt = S_D_RD;
        end
      end
      S_D_MS: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_D_MW;
      end
      S_D_MW: begin
        if (sts.mul_done) begin
          state_nxt = S_D_WR;
        end
      end
      S_D_WR: begin
        cmd.d_we    = 1'b1;
        cmd.mac_clr = 1'b1;
        state_nxt   = S_D_RD;
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = S_REPORT;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      S_REPORT: begin
        cmd.out_report = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      step_r      <= MS_HAB;
      out_valid_r <= 1'b0;
      size_r      <= 5'd16;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      size_r      <= size_nxt;
    end
  end

endmodule

### design/stmp_dpath.sv
`timescale 1ns / 1ps
module stmp_dpath #(
  parameter int MAX_DIM = 16,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int CW = $clog2(MAX_DIM + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stmp_pkg::stmp_cmd_t cmd,
  output stmp_pkg::stmp_sts_t sts,
  input  logic [IW-1:0]       idx_i,
  input  logic [IW-1:0]       idx_j,
  input  logic [IW-1:0]       idx_k,
  input  logic [CW-1:0]       n_use,
  input  logic [1:0]          in_matrix_select,
  input  logic [3:0]          in_row,
  input  logic [3:0]          in_col,
  input  logic [7:0]          in_value,
  output logic                out_result_kind,
  output logic signed [63:0]  out_element,
  output logic signed [63:0]  out_scale,
  output logic                out_divide_by_zero
);
  import stmp_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW    = 16 + $clog2(MAX_DIM) + 1;   // partial product
  localparam int ACCW  = PW + 8 + $clog2(MAX_DIM) + 1; // D accumulator
  localparam int BW    = ACCW;                        // multiplier B operand
  localparam int PRW   = 64 + BW;                     // multiplier product
  localparam int MCW   = $clog2(BW);
  localparam int SUMW  = 8 + AW + 1;
  localparam int XW    = PW + 8;

  // Element addresses
  logic [AW-1:0] addr_ik, addr_jk, addr_ij, addr_in;
  logic          in_pos_ok;
  assign addr_ik   = AW'(32'(idx_i) * MAX_DIM + 32'(idx_k));
  assign addr_jk   = AW'(32'(idx_j) * MAX_DIM + 32'(idx_k));
  assign addr_ij   = AW'(32'(idx_i) * MAX_DIM + 32'(idx_j));
  assign addr_in   = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign in_pos_ok = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);

  logic [7:0]    a_rd, b_rd, c_rd;
  logic [PW-1:0] p_rd;
  logic [63:0]   d_rd;
  logic [AW-1:0] bc_raddr;
  logic          we_a, we_b, we_c;
  logic [PW-1:0] p_wdata;
  logic [63:0]   d_wdata;
  logic [63:0]   d_val_r;
  logic [ACCW-1:0] acc_sum;

  assign bc_raddr = cmd.sel_j ? addr_jk : addr_ik;
  assign we_a     = cmd.load_we && in_pos_ok && (in_matrix_select == SEL_A);
  assign we_b     = cmd.load_we && in_pos_ok && (in_matrix_select == SEL_B);
  assign we_c     = cmd.load_we && in_pos_ok && (in_matrix_select == SEL_C);
  assign p_wdata  = PW'(acc_sum);
  assign d_wdata  = cmd.clr_we ? 64'd0 : d_val_r;

  stmp_ram #(.WIDTH(8), .DEPTH(CELLS)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(addr_in), .wdata(in_value),
    .raddr(addr_ik), .rdata(a_rd)
  );
  stmp_ram #(.WIDTH(8), .DEPTH(CELLS)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(addr_in), .wdata(in_value),
    .raddr(bc_raddr), .rdata(b_rd)
  );
  stmp_ram #(.WIDTH(8), .DEPTH(CELLS)) u_ram_c (
    .clk(clk), .we(we_c), .waddr(addr_in), .wdata(in_value),
    .raddr(bc_raddr), .rdata(c_rd)
  );
  stmp_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_ram_p (
    .clk(clk), .we(cmd.p_we), .waddr(addr_ij), .wdata(p_wdata),
    .raddr(addr_ik), .rdata(p_rd)
  );
  stmp_ram #(.WIDTH(64), .DEPTH(CELLS)) u_ram_d (
    .clk(clk), .we(cmd.clr_we || cmd.d_we), .waddr(addr_ij), .wdata(d_wdata),
    .raddr(addr_in), .rdata(d_rd)
  );

  // Running min, max and sum of each matrix
  logic [7:0]      lo_r [3];
  logic [7:0]      hi_r [3];
  logic [SUMW-1:0] sum_r [3];
  logic [7:0]      st_d [3];
  assign st_d[0] = a_rd;
  assign st_d[1] = b_rd;
  assign st_d[2] = c_rd;

  always_ff @(posedge clk) begin
    if (cmd.st_upd) begin
      for (int g = 0; g < 3; g++) begin
        if (cmd.st_first) begin
          lo_r[g]  <= st_d[g];
          hi_r[g]  <= st_d[g];
          sum_r[g] <= SUMW'(st_d[g]);
        end else begin
          if (st_d[g] < lo_r[g]) lo_r[g] <= st_d[g];
          if (st_d[g] > hi_r[g]) hi_r[g] <= st_d[g];
          sum_r[g] <= sum_r[g] + SUMW'(st_d[g]);
        end
      end
    end
  end

  // Multiply-accumulate for both matrix products
  logic [XW-1:0]   prod_r;
  logic [ACCW-1:0] acc_r;
  assign acc_sum = acc_r + ACCW'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.mac_mul) begin
      if (cmd.mac_d) begin
        prod_r <= XW'(p_rd) * XW'(c_rd);
      end else begin
        prod_r <= XW'(a_rd) * XW'(b_rd);
      end
    end
    if (cmd.mac_clr) begin
      acc_r <= '0;
    end else if (cmd.mac_acc) begin
      acc_r <= acc_sum;
    end
  end

  // Shared shift-add multiplier, one bit of B per cycle
  logic [63:0]     tmp_r, hi_prod_r, num_r, nn_r, den_r, scale_r;
  logic            flag_r;
  logic [63:0]     op_a;
  logic [BW-1:0]   op_b;
  logic [PRW-1:0]  mul_a_r, mul_p_r;
  logic [BW-1:0]   mul_b_r;
  logic [MCW-1:0]  mul_cnt_r;
  logic            mul_busy_r, mul_done_r;
  logic [3:0]      mul_step_r;

  always_comb begin
    case (cmd.mul_step)
      MS_HAB:   begin op_a = 64'(hi_r[0]); op_b = BW'(hi_r[1]); end
      MS_HABC:  begin op_a = tmp_r;        op_b = BW'(hi_r[2]); end
      MS_LAB:   begin op_a = 64'(lo_r[0]); op_b = BW'(lo_r[1]); end
      MS_LABC:  begin op_a = tmp_r;        op_b = BW'(lo_r[2]); end
      MS_N2:    begin op_a = 64'(n_use);   op_b = BW'(n_use);   end
      MS_N3:    begin op_a = tmp_r;        op_b = BW'(n_use);   end
      MS_N6:    begin op_a = tmp_r;        op_b = BW'(tmp_r);   end
      MS_NUM:   begin op_a = tmp_r;        op_b = BW'(num_r);   end
      MS_SAB:   begin op_a = 64'(sum_r[0]); op_b = BW'(sum_r[1]); end
      MS_DEN:   begin op_a = tmp_r;        op_b = BW'(sum_r[2]); end
      MS_SCALE: begin op_a = scale_r;      op_b = BW'(acc_r);   end
      default:  begin op_a = '0;           op_b = '0;           end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
    end else begin
      mul_done_r <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
      end else if (mul_busy_r && (mul_cnt_r == MCW'(BW - 1))) begin
        mul_busy_r <= 1'b0;
        mul_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_a_r    <= PRW'(op_a);
      mul_b_r    <= op_b;
      mul_p_r    <= '0;
      mul_cnt_r  <= '0;
      mul_step_r <= cmd.mul_step;
    end else if (mul_busy_r) begin
      if (mul_b_r[0]) begin
        mul_p_r <= mul_p_r + mul_a_r;
      end
      mul_a_r   <= mul_a_r << 1;
      mul_b_r   <= mul_b_r >> 1;
      mul_cnt_r <= mul_cnt_r + MCW'(1);
    end
  end

  // Capture each finished product where its step sends it
  always_ff @(posedge clk) begin
    if (mul_done_r) begin
      case (mul_step_r)
        MS_HABC:  hi_prod_r <= mul_p_r[63:0];
        MS_LABC:  num_r     <= hi_prod_r - mul_p_r[63:0];
        MS_NUM:   nn_r      <= mul_p_r[63:0];
        MS_DEN:   den_r     <= mul_p_r[63:0];
        MS_SCALE: d_val_r   <= (mul_p_r > PRW'(S64_MAX)) ? S64_MAX : mul_p_r[63:0];
        default:  tmp_r     <= mul_p_r[63:0];
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [64:0] rem_r, div_tmp;
  logic [63:0] quo_r;
  logic [5:0]  div_cnt_r;
  logic        div_busy_r, div_done_r, div_ge;
  assign div_tmp = {rem_r[63:0], quo_r[63]};
  assign div_ge  = (div_tmp >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && (div_cnt_r == 6'd63)) begin
        div_busy_r <= 1'b0;
        div_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r     <= '0;
      quo_r     <= nn_r;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      rem_r     <= div_ge ? (div_tmp - {1'b0, den_r}) : div_tmp;
      quo_r     <= {quo_r[62:0], div_ge};
      div_cnt_r <= div_cnt_r + 6'd1;
    end
  end

  assign sts.mul_done = mul_done_r;
  assign sts.div_done = div_done_r;
  assign sts.den_zero = (den_r == 64'd0);

  // Scale and flag, kept between computes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
      flag_r  <= 1'b0;
    end else if (cmd.scale_load) begin
      scale_r <= sts.den_zero ? 64'd0 : quo_r;
      flag_r  <= sts.den_zero;
    end
  end

  // Output register
  logic        rd_ok_r;
  logic        kind_r;
  logic [63:0] elem_r, oscale_r;
  logic        oflag_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_capture) begin
      rd_ok_r <= (32'(in_row) < 32'(n_use)) && (32'(in_col) < 32'(n_use));
    end
    if (cmd.out_report) begin
      kind_r   <= KIND_REPORT;
      elem_r   <= '0;
      oscale_r <= scale_r;
      oflag_r  <= flag_r;
    end else if (cmd.out_read) begin
      kind_r   <= KIND_READ;
      elem_r   <= rd_ok_r ? d_rd : 64'd0;
      oscale_r <= scale_r;
      oflag_r  <= flag_r;
    end
  end

  assign out_result_kind    = kind_r;
  assign out_element        = elem_r;
  assign out_scale          = oscale_r;
  assign out_divide_by_zero = oflag_r;

endmodule

### tb/scaled_triple_matrix_product_tb.sv
`timescale 1ns / 1ps
module scaled_triple_matrix_product_tb;
  import stmp_pkg::*;

  localparam int DIM = 16;
  localparam int CYCLE = 8;

  // Action and selector codes that the block ignores
  localparam logic [1:0] ACT_NOP  = 2'd3;
  localparam logic [1:0] SEL_NONE = 2'd3;

  typedef struct {
    logic [1:0] action;
    logic [1:0] sel;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] value;
  } stim_t;

  typedef struct {
    logic        kind;
    logic [63:0] element;
    logic [63:0] scale;
    logic        dz;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = ACT_LOAD;
  logic [1:0] in_matrix_select = SEL_A;
  logic [3:0] in_row = '0;
  logic [3:0] in_col = '0;
  logic [7:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_result_kind;
  logic signed [63:0] out_element;
  logic signed [63:0] out_scale;
  logic out_divide_by_zero;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  scaled_triple_matrix_product #(.MAX_DIM(DIM)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_matrix_select(in_matrix_select),
    .in_row(in_row), .in_col(in_col), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_element(out_element),
    .out_scale(out_scale), .out_divide_by_zero(out_divide_by_zero),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock
  always begin
    #(CYCLE / 2) clk = 1'b1;
    #(CYCLE / 2) clk = 1'b0;
  end

  // Mirror of the block's state
  logic [7:0]  mat_a [DIM*DIM];
  logic [7:0]  mat_b [DIM*DIM];
  logic [7:0]  mat_c [DIM*DIM];
  logic [63:0] d_store [DIM*DIM];
  logic [63:0] scale_reg = '0;
  logic        dz_reg = 1'b0;
  logic [4:0]  size_reg = 5'd16;

  // Stimulus bookkeeping
  stim_t   item_q[$];
  result_t expected_q[$];
  bit      loaded [3][DIM*DIM];
  int      issued = 0;
  int      errors = 0;
  bit      send_idle = 1'b0;
  bit      recv_idle = 1'b0;
  bit      long_hold_req = 1'b0;
  logic    in_fire = 1'b0;
  logic    out_fire = 1'b0;
  logic    cfg_fire = 1'b0;

  initial begin
    for (int i = 0; i < DIM*DIM; i++) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
      mat_c[i] = '0;
      d_store[i] = '0;
    end
  end

  function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return (p > S64_MAX) ? S64_MAX : p[63:0];
  endfunction

  function automatic int size_used();
    if (size_reg == 0) return 1;
    if (size_reg > DIM) return DIM;
    return int'(size_reg);
  endfunction

  task automatic matrix_stats(input logic [7:0] m [DIM*DIM], input int n,
                              output logic [63:0] lo, output logic [63:0] hi,
                              output logic [63:0] sum);
    lo = m[0];
    hi = m[0];
    sum = '0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if (m[r*DIM+c] < lo) lo = m[r*DIM+c];
        if (m[r*DIM+c] > hi) hi = m[r*DIM+c];
        sum += m[r*DIM+c];
      end
  endtask

  // Compute: statistics, scale, then D = scale * (A * B^T) * C^T
  task automatic run_product();
    logic [63:0] loa, hia, suma, lob, hib, sumb, loc, hic, sumc;
    logic [63:0] num, n6, den, q, acc;
    logic [63:0] part [DIM*DIM];
    int n;
    n = size_used();
    matrix_stats(mat_a, n, loa, hia, suma);
    matrix_stats(mat_b, n, lob, hib, sumb);
    matrix_stats(mat_c, n, loc, hic, sumc);
    num = hia * hib * hic - loa * lob * loc;
    n6 = 64'(n * n * n);
    n6 = n6 * n6;
    den = suma * sumb * sumc;
    if (den == 0) begin
      dz_reg = 1'b1;
      scale_reg = '0;
    end else begin
      dz_reg = 1'b0;
      q = sat_mul(num, n6) / den;
      scale_reg = (q > S64_MAX) ? S64_MAX : q;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) acc += mat_a[i*DIM+k] * mat_b[j*DIM+k];
        part[i*DIM+j] = acc;
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) acc += part[i*DIM+k] * mat_c[j*DIM+k];
        d_store[i*DIM+j] = sat_mul(acc, scale_reg);
      end
  endtask

  // Advance the mirror by one accepted item and queue what it should produce
  task automatic predict_item();
    result_t r;
    int n;
    case (in_action)
      ACT_LOAD: begin
        case (in_matrix_select)
          SEL_A: mat_a[in_row*DIM+in_col] = in_value;
          SEL_B: mat_b[in_row*DIM+in_col] = in_value;
          SEL_C: mat_c[in_row*DIM+in_col] = in_value;
          default: ;
        endcase
      end
      ACT_COMPUTE: begin
        run_product();
        r.kind = KIND_REPORT;
        r.element = '0;
        r.scale = scale_reg;
        r.dz = dz_reg;
        expected_q.push_back(r);
      end
      ACT_READ: begin
        n = size_used();
        r.kind = KIND_READ;
        r.element = (in_row < n && in_col < n) ? d_store[in_row*DIM+in_col] : '0;
        r.scale = scale_reg;
        r.dz = dz_reg;
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Monitor: sample transfers, check results
  always @(posedge clk) begin
    result_t e;
    in_fire <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (in_valid && in_ready) predict_item();
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result kind=%0d element=%0d",
                                     out_result_kind, out_element);
        end else begin
          e = expected_q.pop_front();
          if (out_result_kind !== e.kind || out_element !== e.element ||
              out_scale !== e.scale || out_divide_by_zero !== e.dz) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp kind=%0d el=%0d sc=%0d dz=%0d, got %0d %0d %0d %0d",
                       e.kind, e.element, e.scale, e.dz, out_result_kind,
                       out_element, out_scale, out_divide_by_zero);
          end
        end
      end
    end
  end

  // Driver: hold the current item until its transfer, then idle or advance
  always @(negedge clk) begin
    stim_t s;
    int gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (gap > 0) begin
      gap--;
      in_valid <= 1'b0;
    end else if (item_q.size() > 0) begin
      s = item_q.pop_front();
      in_action <= s.action;
      in_matrix_select <= s.sel;
      in_row <= s.row;
      in_col <= s.col;
      in_value <= s.value;
      in_valid <= 1'b1;
      gap = send_idle ? $urandom_range(0, 3) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls per result, plus one long hold on the first
  // result after the request
  always @(negedge clk) begin
    int stall;
    int hold;
    if (out_fire) stall = recv_idle ? $urandom_range(0, 3) : 0;
    if (long_hold_req && out_valid) begin
      hold = 400;
      long_hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold > 0) begin
      hold--;
      out_ready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push(logic [1:0] act, int sel, int row, int col, int val);
    stim_t s;
    s.action = act;
    s.sel = 2'(sel);
    s.row = 4'(row);
    s.col = 4'(col);
    s.value = 8'(val);
    item_q.push_back(s);
    if (act != ACT_NOP) issued++;
    if (act == ACT_LOAD && sel != SEL_NONE) loaded[sel][row*DIM+col] = 1'b1;
  endtask

  // Wait until every item is taken and every result is in
  task automatic drain();
    while (item_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= 5'(v);
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_value();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Load every element of the active corner that was never written
  task automatic fill_missing(int n);
    for (int m = 0; m < 3; m++)
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          if (!loaded[m][r*DIM+c]) push(ACT_LOAD, m, r, c, rand_value());
  endtask

  // Timeout
  initial begin
    #30ms;
    $display("scaled_triple_matrix_product_tb NOT OK");
    $finish;
  end

  initial begin
    int n, cfgv, cnt, phase;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: all zero matrices give a zero divisor
    write_size(1);
    push(ACT_LOAD, SEL_A, 0, 0, 0);
    push(ACT_LOAD, SEL_B, 0, 0, 0);
    push(ACT_LOAD, SEL_C, 0, 0, 0);
    push(ACT_READ, SEL_A, 0, 0, 0);
    push(ACT_COMPUTE, SEL_A, 0, 0, 0);
    push(ACT_READ, SEL_A, 0, 0, 0);
    push(ACT_READ, SEL_A, 15, 15, 0);
    push(ACT_NOP, SEL_NONE, 15, 15, 255);
    push(ACT_LOAD, SEL_NONE, 15, 15, 255);
    // equal extremes give a zero numerator
    push(ACT_LOAD, SEL_A, 0, 0, 255);
    push(ACT_LOAD, SEL_B, 0, 0, 255);
    push(ACT_LOAD, SEL_C, 0, 0, 255);
    push(ACT_COMPUTE, SEL_A, 0, 0, 0);
    push(ACT_READ, SEL_A, 0, 0, 0);
    drain();
    // size zero acts as one
    write_size(0);
    push(ACT_LOAD, SEL_A, 15, 15, 1);
    push(ACT_COMPUTE, SEL_A, 0, 0, 0);
    push(ACT_READ, SEL_A, 0, 0, 0);
    push(ACT_READ, SEL_A, 0, 1, 0);
    drain();
    // size above the maximum acts as the maximum; one small element
    write_size(31);
    push(ACT_LOAD, SEL_A, 3, 7, 1);
    fill_missing(DIM);
    push(ACT_COMPUTE, SEL_A, 0, 0, 0);
    push(ACT_READ, SEL_A, 15, 15, 0);
    push(ACT_READ, SEL_A, 0, 0, 0);
    drain();

    // Random phases
    phase = 0;
    while (issued < 1900) begin
      phase++;
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 5);
      cfgv = n;
      if (n == 16 && $urandom_range(0, 1)) cfgv = $urandom_range(17, 31);
      if (n == 1 && $urandom_range(0, 1)) cfgv = 0;
      write_size(cfgv);
      fill_missing(n);
      // occasionally clear one matrix's active corner for a zero divisor
      if ($urandom_range(0, 7) == 0) begin
        cnt = $urandom_range(0, 2);
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) push(ACT_LOAD, cnt, r, c, 0);
      end
      cnt = $urandom_range(0, 2 * n * n);
      for (int i = 0; i < cnt; i++)
        push(ACT_LOAD, $urandom_range(0, 3), $urandom_range(0, 15),
             $urandom_range(0, 15), rand_value());
      if ($urandom_range(0, 3) == 0) push(ACT_NOP, $urandom_range(0, 3),
                                          $urandom_range(0, 15),
                                          $urandom_range(0, 15), rand_value());
      push(ACT_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 15),
           $urandom_range(0, 15), rand_value());
      if (phase == 3) long_hold_req = 1'b1;
      cnt = (phase == 3) ? 20 : $urandom_range(2, 8);
      for (int i = 0; i < cnt; i++)
        push(ACT_READ, $urandom_range(0, 3),
             $urandom_range(0, 2) ? $urandom_range(0, n - 1) : $urandom_range(0, 15),
             $urandom_range(0, 2) ? $urandom_range(0, n - 1) : $urandom_range(0, 15),
             rand_value());
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("scaled_triple_matrix_product_tb OK");
    end else begin
      $display("scaled_triple_matrix_product_tb NOT OK");
    end
    $finish;
  end

endmodule
